@@ rtl/http_get_request_checker_core_defines.svh @@
// Assertion macros for the HTTP GET request checker core.
// Used by the top level only; depends on clk_i and rst_ni being in scope.
`ifndef HTTP_GET_REQUEST_CHECKER_CORE_DEFINES_SVH
`define HTTP_GET_REQUEST_CHECKER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define HGRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("hgrc assertion failed");

// Condition now implies a consequence at the next clock edge.
`define HGRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hgrc assertion failed");

`endif

@@ rtl/hgrc_pkg.sv @@
// Types, byte constants and helper functions for the HTTP GET request checker.
// No dependencies; imported by hgrc_step and the top level.
package hgrc_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_REQLINE,
    PH_HEADERS,
    PH_VALID,
    PH_BAD
  } phase_e;

  // Field of the request line that is being read.
  typedef enum logic [2:0] {
    FS_METHOD,
    FS_GAP1,
    FS_URL,
    FS_GAP2,
    FS_VERSION,
    FS_FAILED
  } field_e;

  typedef struct packed {
    phase_e     phase;
    field_e     field;
    logic [3:0] match_pos;
    logic       cr_pending;
    logic       has_content;
    logic       zero_seen;
  } parse_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic       line_end;
  } result_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:       PH_REQLINE,
    field:       FS_METHOD,
    match_pos:   4'd0,
    cr_pending:  1'b0,
    has_content: 1'b0,
    zero_seen:   1'b0
  };

  // Status codes.
  localparam logic [1:0] STATUS_MORE = 2'd0;
  localparam logic [1:0] STATUS_OK   = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  // Bytes with a special meaning.
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_SP  = 8'h20;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_NUL = 8'h00;

  localparam logic [3:0] METHOD_LEN  = 4'd3;
  localparam logic [3:0] VERSION_LEN = 4'd8;

  // Map upper-case letters to lower case.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5a) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return (b == BYTE_SP) || (b == BYTE_TAB);
  endfunction

  // Lower-case text of the method, "get".
  function automatic logic [7:0] method_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h67;
      2'd1:    c = 8'h65;
      2'd2:    c = 8'h74;
      default: c = BYTE_NUL;
    endcase
    return c;
  endfunction

  // Lower-case text of the version, "http/1.1".
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h68;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h70;
      3'd4:    c = 8'h2f;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2e;
      3'd7:    c = 8'h31;
      default: c = BYTE_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/http_get_request_checker_core.sv @@
// HTTP GET request checker: one status result for each request byte.
// Each accepted byte passes the input register, then the result register (or the skid entry first).
// Throughput: one byte per cycle while the skid entry is free; the parser state loop is a single register.
// A two-entry output buffer keeps input flowing while the output stalls, until the skid entry is full.
// Reset (rst_ni low, asynchronous) empties all stages and restarts the parser.
// Depends on hgrc_pkg, hgrc_step and http_get_request_checker_core_defines.svh.
`include "http_get_request_checker_core_defines.svh"

module http_get_request_checker_core import hgrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       new_request_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       line_end_o
);

  logic         in_v_q;
  logic [7:0]   byte_q;
  logic         new_q;
  logic         in_take;
  logic         stage_go;
  logic         pop;
  parse_state_t state_q;
  parse_state_t state_d;
  result_t      res_d;
  logic         out_v_q;
  result_t      out_q;
  logic         skid_v_q;
  result_t      skid_q;

  // The stage moves when the skid entry is free to catch its item.
  assign stage_go   = in_v_q && !skid_v_q;
  assign in_ready_o = !in_v_q || stage_go;
  assign in_take    = in_valid_i && in_ready_o;
  assign pop        = out_v_q && out_ready_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      new_q  <= new_request_i;
    end
  end

  hgrc_step u_step (
    .state_i       (state_q),
    .data_byte_i   (byte_q),
    .new_request_i (new_q),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  // Parser state advances once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_RESET;
    end else if (stage_go) begin
      state_q <= state_d;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !pop) begin
      if (stage_go) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= stage_go;
    end else begin
      out_v_q <= stage_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !pop) begin
      if (stage_go) begin
        skid_q <= res_d;
      end
    end else if (skid_v_q) begin
      out_q <= skid_q;
      if (stage_go) begin
        skid_q <= res_d;
      end
    end else if (stage_go) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign status_o    = out_q.status;
  assign line_end_o  = out_q.line_end;

  // The skid entry only fills behind a waiting result.
  `HGRC_ASSERT(a_skid_behind_out, !skid_v_q || out_v_q)
  // A stalled result with a byte in flight must catch it in the skid entry.
  `HGRC_ASSERT_NEXT(a_skid_catch, out_v_q && !out_ready_i && stage_go, skid_v_q)
  // Every result carries one of the defined status codes.
  `HGRC_ASSERT(a_status_code, !out_v_q || out_q.status == STATUS_MORE || out_q.status == STATUS_OK || out_q.status == STATUS_BAD)
  // Once final, the parser leaves its phase only on a new-request mark.
  `HGRC_ASSERT_NEXT(a_final_holds,
                    stage_go && !new_q && (state_q.phase == PH_VALID || state_q.phase == PH_BAD),
                    state_q.phase == $past(state_q.phase))

endmodule

@@ rtl/hgrc_step.sv @@
// Next-state and result logic of the request parser for one byte.
// Purely combinational; depends on hgrc_pkg.
module hgrc_step import hgrc_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         new_request_i,
  output parse_state_t state_o,
  output result_t      result_o
);

  parse_state_t cur;
  parse_state_t nxt;
  logic [7:0]   folded;
  logic         blank;
  logic         line_end;

  assign folded = fold_case(data_byte_i);
  assign blank  = is_blank(data_byte_i);

  always_comb begin
    // A new-request mark restarts the parser before this byte is taken.
    cur      = new_request_i ? PARSE_RESET : state_i;
    nxt      = cur;
    line_end = 1'b0;

    if (cur.phase == PH_VALID || cur.phase == PH_BAD) begin
      // Final status holds until the next new request.
      nxt = cur;
    end else if (cur.cr_pending) begin
      if (data_byte_i == BYTE_LF) begin
        // End of a line: judge it, then clear the per-line state.
        line_end = 1'b1;
        nxt      = PARSE_RESET;
        if (cur.phase == PH_REQLINE) begin
          if (cur.field == FS_VERSION && cur.match_pos == VERSION_LEN) begin
            nxt.phase = PH_HEADERS;
          end else begin
            nxt.phase = PH_BAD;
          end
        end else if (!cur.has_content) begin
          nxt.phase = PH_VALID;
        end else begin
          nxt.phase = cur.phase;
        end
      end else begin
        nxt.phase = PH_BAD;
      end
    end else if (data_byte_i == BYTE_CR) begin
      nxt.cr_pending = 1'b1;
    end else if (data_byte_i == BYTE_LF) begin
      nxt.phase = PH_BAD;
    end else if (cur.zero_seen) begin
      // The rest of the line is hidden.
      nxt = cur;
    end else if (data_byte_i == BYTE_NUL) begin
      nxt.zero_seen = 1'b1;
    end else begin
      nxt.has_content = 1'b1;
      if (cur.phase == PH_REQLINE) begin
        // Walk the fields of the request line.
        case (cur.field)
          FS_METHOD: begin
            if (blank) begin
              if (cur.match_pos == METHOD_LEN) begin
                nxt.field     = FS_GAP1;
                nxt.match_pos = 4'd0;
              end else begin
                nxt.field = FS_FAILED;
              end
            end else if (cur.match_pos < METHOD_LEN &&
                         folded == method_char(cur.match_pos[1:0])) begin
              nxt.match_pos = cur.match_pos + 4'd1;
            end else begin
              nxt.field = FS_FAILED;
            end
          end
          FS_GAP1: begin
            if (!blank) begin
              nxt.field = FS_URL;
            end
          end
          FS_URL: begin
            if (blank) begin
              nxt.field = FS_GAP2;
            end
          end
          FS_GAP2: begin
            if (!blank) begin
              if (folded == version_char(3'd0)) begin
                nxt.field     = FS_VERSION;
                nxt.match_pos = 4'd1;
              end else begin
                nxt.field     = FS_FAILED;
                nxt.match_pos = 4'd0;
              end
            end
          end
          FS_VERSION: begin
            if (cur.match_pos < VERSION_LEN &&
                folded == version_char(cur.match_pos[2:0])) begin
              nxt.match_pos = cur.match_pos + 4'd1;
            end else begin
              nxt.field = FS_FAILED;
            end
          end
          default: begin
            nxt.field = cur.field;
          end
        endcase
      end
    end
  end

  // Status follows the phase after this byte.
  always_comb begin
    case (nxt.phase)
      PH_VALID: result_o.status = STATUS_OK;
      PH_BAD:   result_o.status = STATUS_BAD;
      default:  result_o.status = STATUS_MORE;
    endcase
    result_o.line_end = line_end;
  end

  assign state_o = nxt;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for http_get_request_checker_core, a byte-serial HTTP GET checker.
// Depends on hgrc_pkg and the core; a directed item table runs first, then random requests.
// Every status and line_end result is checked against typed-in values or a behavioral parser kept in this file.
module tb_top;
  import hgrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 300000;
  localparam int RANDOM_BYTES = 1400;
  localparam int N_ROWS       = 28;
  localparam int MAX_REPORTS  = 10;

  // Lower-case texts that the request line must carry.
  localparam logic [7:0] METHOD_TXT [3] = '{"g", "e", "t"};
  localparam logic [7:0] VERSION_TXT [8] = '{"h", "t", "t", "p", "/", "1", ".", "1"};

  // One directed item; the expected result is typed in where typed is set.
  typedef struct packed {
    logic [7:0] data;
    logic       nr;
    logic       typed;
    logic [1:0] status;
    logic       line_end;
  } stim_row_t;

  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    '{8'hff,    1'b1, 1'b1, STATUS_MORE, 1'b0},  // top byte starts a request
    '{BYTE_LF,  1'b0, 1'b1, STATUS_BAD,  1'b0},  // lone LF
    '{BYTE_NUL, 1'b0, 1'b1, STATUS_BAD,  1'b0},  // bad status holds
    '{BYTE_CR,  1'b1, 1'b1, STATUS_MORE, 1'b0},
    '{"A",      1'b0, 1'b1, STATUS_BAD,  1'b0},  // CR without LF
    '{"x",      1'b1, 1'b1, STATUS_MORE, 1'b0},
    '{BYTE_CR,  1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_LF,  1'b0, 1'b1, STATUS_BAD,  1'b1},  // wrong method shows at the LF
    '{"g",      1'b1, 1'b0, STATUS_MORE, 1'b0},
    '{"E",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"t",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_TAB, 1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"/",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_SP,  1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"h",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"T",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"t",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"P",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"/",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"1",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{".",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{"1",      1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_CR,  1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_LF,  1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_NUL, 1'b0, 1'b0, STATUS_MORE, 1'b0},  // header line hidden by a zero byte
    '{BYTE_CR,  1'b0, 1'b0, STATUS_MORE, 1'b0},
    '{BYTE_LF,  1'b0, 1'b1, STATUS_OK,   1'b1},  // counts as the empty line
    '{"Z",      1'b0, 1'b1, STATUS_OK,   1'b0}   // valid status holds
  };

  logic       clk_i;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic [7:0] data_byte   = 8'h00;
  logic       new_req     = 1'b0;
  logic       out_ready   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic       line_end_o;

  // Parser state mirrored by the testbench.
  phase_e     ph;
  field_e     fld;
  logic [3:0] mpos;
  logic       cr_seen;
  logic       content;
  logic       zero_hit;

  result_t    due_results [$];
  logic [7:0] req_bytes [$];
  int         mismatches   = 0;
  int         live_bytes   = 0;
  int         results_seen = 0;
  int         tx_count     = 0;
  int         tx_mode      = 0;
  int         cycles       = 0;

  http_get_request_checker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte),
    .new_request_i (new_req),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .status_o      (status_o),
    .line_end_o    (line_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Start of a new line of the request.
  function automatic void restart_line();
    fld      = FS_METHOD;
    mpos     = 4'd0;
    cr_seen  = 1'b0;
    content  = 1'b0;
    zero_hit = 1'b0;
  endfunction

  // Advance the parser by one item and return the result it gives.
  function automatic result_t parse_byte(input logic [7:0] b, input logic nr);
    result_t    r;
    logic [7:0] c;
    logic       blank;
    int         k;
    r.line_end = 1'b0;
    c     = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    blank = (b == BYTE_SP) || (b == BYTE_TAB);
    if (nr) begin
      ph = PH_REQLINE;
      restart_line();
    end
    k = mpos;
    if (ph == PH_VALID || ph == PH_BAD) begin
      // Final status is held.
    end else if (cr_seen) begin
      if (b == BYTE_LF) begin
        r.line_end = 1'b1;
        if (ph == PH_REQLINE) begin
          ph = (fld == FS_VERSION && mpos == VERSION_LEN) ? PH_HEADERS : PH_BAD;
        end else if (!content) begin
          ph = PH_VALID;
        end
        restart_line();
      end else begin
        ph = PH_BAD;
      end
    end else if (b == BYTE_CR) begin
      cr_seen = 1'b1;
    end else if (b == BYTE_LF) begin
      ph = PH_BAD;
    end else if (zero_hit) begin
      // The rest of the line is hidden.
    end else if (b == BYTE_NUL) begin
      zero_hit = 1'b1;
    end else begin
      content = 1'b1;
      if (ph == PH_REQLINE) begin
        case (fld)
          FS_METHOD: begin
            if (blank) begin
              fld  = (mpos == METHOD_LEN) ? FS_GAP1 : FS_FAILED;
              mpos = 4'd0;
            end else if (k < 3 && c == METHOD_TXT[k]) begin
              mpos = mpos + 4'd1;
            end else begin
              fld = FS_FAILED;
            end
          end
          FS_GAP1: begin
            if (!blank) fld = FS_URL;
          end
          FS_URL: begin
            if (blank) fld = FS_GAP2;
          end
          FS_GAP2: begin
            if (!blank) begin
              fld  = (c == VERSION_TXT[0]) ? FS_VERSION : FS_FAILED;
              mpos = (c == VERSION_TXT[0]) ? 4'd1 : 4'd0;
            end
          end
          FS_VERSION: begin
            if (k < 8 && c == VERSION_TXT[k]) begin
              mpos = mpos + 4'd1;
            end else begin
              fld = FS_FAILED;
            end
          end
          default: ;
        endcase
      end
    end
    case (ph)
      PH_VALID: r.status = STATUS_OK;
      PH_BAD:   r.status = STATUS_BAD;
      default:  r.status = STATUS_MORE;
    endcase
    return r;
  endfunction

  // Wait drawn for one item: uniform, none, or mostly none.
  function automatic int draw_wait(input int mode);
    if (mode == 1) return 0;
    if (mode == 2) return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
    return $urandom_range(0, 12);
  endfunction

  // Offer one item, wait for it to be taken, and queue its expected result.
  task automatic send_byte(input logic [7:0] b, input logic nr, input logic typed,
                           input result_t typed_res);
    int      gap;
    result_t r;
    if (tx_count % 64 == 0) tx_mode = $urandom_range(0, 2);
    tx_count++;
    gap = draw_wait(tx_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    new_req   <= nr;
    do @(posedge clk_i); while (!(in_valid && in_ready_o));
    if (nr || !(ph == PH_VALID || ph == PH_BAD)) live_bytes++;
    r = parse_byte(b, nr);
    due_results.push_back(typed ? typed_res : r);
  endtask

  // A byte that may stand in a URL: not blank, CR, LF or zero.
  function automatic logic [7:0] rand_visible();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == BYTE_SP || b == BYTE_TAB || b == BYTE_CR || b == BYTE_LF);
    return b;
  endfunction

  // Upper-case a letter at random.
  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'd32;
    return c;
  endfunction

  // Fill req_bytes with one request: mostly well formed, some damaged, some noise.
  task automatic build_request();
    int         kind;
    int         n;
    int         pos;
    logic [7:0] b;
    req_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0:       b = BYTE_CR;
          1:       b = BYTE_LF;
          2:       b = BYTE_NUL;
          default: b = 8'($urandom_range(0, 255));
        endcase
        req_bytes.push_back(b);
      end
    end else begin
      for (int i = 0; i < 3; i++) req_bytes.push_back(rand_case(METHOD_TXT[i]));
      repeat ($urandom_range(1, 3))
        req_bytes.push_back($urandom_range(0, 1) ? BYTE_SP : BYTE_TAB);
      repeat ($urandom_range(1, 6))
        req_bytes.push_back(($urandom_range(0, 15) == 0) ? BYTE_NUL : rand_visible());
      repeat ($urandom_range(1, 3))
        req_bytes.push_back($urandom_range(0, 1) ? BYTE_SP : BYTE_TAB);
      for (int i = 0; i < 8; i++) req_bytes.push_back(rand_case(VERSION_TXT[i]));
      req_bytes.push_back(BYTE_CR);
      req_bytes.push_back(BYTE_LF);
      // Header lines with arbitrary content, then the empty line.
      repeat ($urandom_range(0, 3)) begin
        repeat ($urandom_range(1, 10)) begin
          do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR || b == BYTE_LF);
          req_bytes.push_back(($urandom_range(0, 15) == 0) ? BYTE_NUL : b);
        end
        req_bytes.push_back(BYTE_CR);
        req_bytes.push_back(BYTE_LF);
      end
      if ($urandom_range(0, 3) == 0) req_bytes.push_back(BYTE_NUL);
      req_bytes.push_back(BYTE_CR);
      req_bytes.push_back(BYTE_LF);
      // Damage a few requests: replace, insert, drop or cut off a byte.
      if (kind <= 3) begin
        pos = $urandom_range(0, req_bytes.size() - 1);
        b   = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
          0: req_bytes[pos] = b;
          1: req_bytes.insert(pos, b);
          2: req_bytes.delete(pos);
          default: while (req_bytes.size() > pos + 1) void'(req_bytes.pop_back());
        endcase
      end
      repeat ($urandom_range(0, 2)) req_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus: reset, directed table, random requests, then drain.
  initial begin : stimulus
    result_t typed_res;
    ph = PH_REQLINE;
    restart_line();
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      typed_res.status   = DIR_ROWS[i].status;
      typed_res.line_end = DIR_ROWS[i].line_end;
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].nr, DIR_ROWS[i].typed, typed_res);
    end

    typed_res  = '0;
    live_bytes = 0;
    while (live_bytes < RANDOM_BYTES) begin
      build_request();
      foreach (req_bytes[i]) begin
        send_byte(req_bytes[i], (i == 0) || ($urandom_range(0, 299) == 0), 1'b0, typed_res);
      end
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result side: random stalls, two long hold-offs so the core backs up, and checking.
  initial begin : drain
    int      stall;
    int      rx_mode;
    result_t want;
    rx_mode = 0;
    wait (rst_n);
    forever begin
      if (results_seen % 64 == 0) rx_mode = $urandom_range(0, 2);
      stall = draw_wait(rx_mode);
      if (results_seen == 250 || results_seen == 800) stall = 90;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready));
      results_seen++;
      if (due_results.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("result %0d arrived with none expected: status %0d line_end %0d",
                   results_seen, status_o, line_end_o);
        end
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status || line_end_o !== want.line_end) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result %0d: status exp %0d got %0d, line_end exp %0d got %0d",
                     results_seen, want.status, status_o, want.line_end, line_end_o);
          end
          mismatches++;
        end
      end
    end
  end

endmodule
